@@ sv/pcc_pkg.sv @@
// shared types and constants of the polyline circle clipper
package pcc_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_W        = 32;
  localparam int RADIUS_W       = 31;
  localparam int WORD_W         = 64;
  localparam int WIDE_W         = 128;
  localparam int CFG_IDX_W      = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CENTER_X    = 3'd0;
  localparam cfg_idx_t CFG_CENTER_Y    = 3'd1;
  localparam cfg_idx_t CFG_RADIUS      = 3'd2;
  localparam cfg_idx_t CFG_CROPPED     = 3'd3;
  localparam cfg_idx_t CFG_SHOW_HIDDEN = 3'd4;
  localparam cfg_idx_t CFG_HIDE_TANGENT = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      edge_last;
    logic                      hidden;
    logic                      smooth;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      piece_end;
    logic                      overflow;
  } out_t;

endpackage

@@ sv/polyline_circle_clipper_top.sv @@
// top level of the polyline circle clipper: sequencer, point store and result register
//
// Points of polyline edges arrive one beat at a time; each segment from the
// previous point is clipped exactly against the configured circle. One point
// is worked on at a time. A segment needs up to nine 64x64 products on one
// shared 32x32 multiplier, which is all it needs when it misses early, plus
// the square root and, for each clipped end point inside the circle, one
// product and a 128-step divide per axis.
// Results leave through a single output register; an uncropped edge is
// replayed from the point store with one ram read per point. Configuration
// beats are taken at any time but must only be sent while the block is idle.
module polyline_circle_clipper_top #(
  parameter int MAX_POINTS = pcc_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pcc_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pcc_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcc_pkg::COORD_W-1:0]      cfg_data
);
  import pcc_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_MUL, S_MWAIT, S_SQRT, S_SWAIT, S_NCHK, S_OFF, S_OFF_MW,
    S_OFF_DW, S_SEG, S_EMIT1, S_START, S_TAIL, S_ELAST, S_RD_ADDR, S_RD_OUT
  } state_t;

  // products of the quadratic, in issue order
  typedef enum logic [3:0] {
    MOP_DXX, MOP_DYY, MOP_FXX, MOP_FYY, MOP_RR, MOP_FXDX, MOP_FYDY, MOP_HH, MOP_QAQC
  } mop_t;

  state_t state_r;
  mop_t   mop_r;

  // configuration
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic [RADIUS_W-1:0]       rad_r;
  logic                      cropped_r, show_hidden_r, hide_tangent_r;

  // edge state
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r, held_x_r, held_y_r;
  logic                      have_prev_r, held_valid_r, supp_r, touched_r, ovf_r;
  logic [CW-1:0]             cnt_r;

  // current segment
  logic signed [COORD_W-1:0] ax_r, ay_r, px_r, py_r;
  logic signed [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic                      last_r;
  logic signed [COORD_W:0]   dxf_r, dyf_r, fxf_r, fyf_r;
  logic [COORD_W-1:0]        dxm_r, dym_r, fxm_r, fym_r, dx_full_r, dy_full_r;
  logic                      dx_neg_r, dy_neg_r, fx_neg_r, fy_neg_r;
  logic [RADIUS_W-1:0]       rm_r;
  logic [WORD_W-1:0]         qa_r;
  logic signed [WORD_W-1:0]  qc_r, h_r;
  logic signed [WIDE_W-1:0]  disc_r;
  logic signed [WORD_W+1:0]  n0_r, n1_r, qa_ext;
  logic                      hit_r, quad_r, start_int_r, end_int_r, go_start_r;
  logic [2:0]                off_sel_r;
  logic [AW-1:0]             rd_idx_r;

  // result register
  logic                      out_valid_r;
  out_t                      out_data_r;

  // arithmetic units
  logic                      mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
  logic [WORD_W-1:0]         mul_a, mul_b, sqrt_root, div_quo;
  logic [WIDE_W-1:0]         mul_prod, div_num;

  // point store
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr;
  logic [2*COORD_W-1:0]      ram_rdata;

  logic                      accept, out_free, crop_on, piece_w, moved_w, off_need, rd_end;
  logic [CW-1:0]             cnt_eff;
  logic [COORD_W:0]          mdx, mdy, mfx, mfy;
  logic                      shift_k;
  logic [WORD_W-1:0]         h_mag, qc_mag, num_sel;
  logic [COORD_W-1:0]        off_base, off_val;

  function automatic logic [COORD_W:0] mag33(input logic signed [COORD_W:0] v);
    mag33 = v[COORD_W] ? -v : v;
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a fresh edge restarts the fill count
  assign cnt_eff   = have_prev_r ? cnt_r : '0;
  assign ram_we    = accept && (cnt_eff < CW'(MAX_POINTS));
  assign ram_waddr = cnt_eff[AW-1:0];
  assign ram_re    = (state_r == S_RD_ADDR);
  assign rd_end    = (CW'(rd_idx_r) + CW'(1)) == cnt_r;

  // operand magnitudes, halved together when any of them reaches 2^31
  assign mdx     = mag33(dxf_r);
  assign mdy     = mag33(dyf_r);
  assign mfx     = mag33(fxf_r);
  assign mfy     = mag33(fyf_r);
  assign shift_k = mdx[31] | mdy[31] | mfx[31] | mfy[31];

  assign h_mag   = h_r[WORD_W-1] ? -h_r : h_r;
  assign qc_mag  = qc_r[WORD_W-1] ? -qc_r : qc_r;
  assign qa_ext  = $signed({2'b00, qa_r});

  assign off_need = off_sel_r[1] ? end_int_r : start_int_r;
  assign num_sel  = off_sel_r[1] ? n1_r[WORD_W-1:0] : n0_r[WORD_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_OFF) begin
      mul_a = num_sel;
      mul_b = {32'd0, off_sel_r[0] ? dy_full_r : dx_full_r};
    end else begin
      unique case (mop_r)
        MOP_DXX:  begin mul_a = {32'd0, dxm_r}; mul_b = {32'd0, dxm_r}; end
        MOP_DYY:  begin mul_a = {32'd0, dym_r}; mul_b = {32'd0, dym_r}; end
        MOP_FXX:  begin mul_a = {32'd0, fxm_r}; mul_b = {32'd0, fxm_r}; end
        MOP_FYY:  begin mul_a = {32'd0, fym_r}; mul_b = {32'd0, fym_r}; end
        MOP_RR:   begin mul_a = {33'd0, rm_r};  mul_b = {33'd0, rm_r};  end
        MOP_FXDX: begin mul_a = {32'd0, fxm_r}; mul_b = {32'd0, dxm_r}; end
        MOP_FYDY: begin mul_a = {32'd0, fym_r}; mul_b = {32'd0, dym_r}; end
        MOP_HH:   begin mul_a = h_mag;          mul_b = h_mag;          end
        MOP_QAQC: begin mul_a = qa_r;           mul_b = qc_mag;         end
        default:  begin mul_a = '0;             mul_b = '0;             end
      endcase
    end
  end

  assign mul_start  = (state_r == S_MUL) || (state_r == S_OFF && !off_sel_r[2] && off_need);
  assign sqrt_start = (state_r == S_SQRT) && !disc_r[WIDE_W-1];
  // rounded offset: (2 n |d| + qa) / (2 qa)
  assign div_start  = (state_r == S_OFF_MW) && mul_done;
  assign div_num    = {mul_prod[WIDE_W-2:0], 1'b0} + {64'd0, qa_r};

  assign off_base = off_sel_r[0] ? ay_r : ax_r;
  assign off_val  = (off_sel_r[0] ? dy_neg_r : dx_neg_r) ? off_base - div_quo[COORD_W-1:0]
                                                          : off_base + div_quo[COORD_W-1:0];

  assign crop_on = cropped_r && !supp_r;
  assign piece_w = quad_r && !(x0_r == x1_r && y0_r == y1_r);
  assign moved_w = (held_x_r != x0_r) || (held_y_r != y0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      mop_r          <= MOP_DXX;
      cx_r           <= '0;
      cy_r           <= '0;
      rad_r          <= '0;
      cropped_r      <= 1'b1;
      show_hidden_r  <= 1'b1;
      hide_tangent_r <= 1'b0;
      have_prev_r    <= 1'b0;
      held_valid_r   <= 1'b0;
      supp_r         <= 1'b0;
      touched_r      <= 1'b0;
      ovf_r          <= 1'b0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CENTER_X:     cx_r           <= cfg_data;
          CFG_CENTER_Y:     cy_r           <= cfg_data;
          CFG_RADIUS:       rad_r          <= cfg_data[RADIUS_W-1:0];
          CFG_CROPPED:      cropped_r      <= cfg_data[0];
          CFG_SHOW_HIDDEN:  show_hidden_r  <= cfg_data[0];
          CFG_HIDE_TANGENT: hide_tangent_r <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (!have_prev_r) begin
              supp_r       <= (in_data.hidden && !show_hidden_r) ||
                              (in_data.smooth && hide_tangent_r);
              touched_r    <= 1'b0;
              held_valid_r <= 1'b0;
            end
            if (ram_we) begin
              cnt_r <= cnt_eff + CW'(1);
              ovf_r <= have_prev_r && ovf_r;
            end else begin
              cnt_r <= cnt_eff;
              ovf_r <= 1'b1;
            end
            ax_r        <= prev_x_r;
            ay_r        <= prev_y_r;
            px_r        <= in_data.point_x;
            py_r        <= in_data.point_y;
            last_r      <= in_data.edge_last;
            dxf_r       <= {in_data.point_x[COORD_W-1], in_data.point_x} -
                           {prev_x_r[COORD_W-1], prev_x_r};
            dyf_r       <= {in_data.point_y[COORD_W-1], in_data.point_y} -
                           {prev_y_r[COORD_W-1], prev_y_r};
            fxf_r       <= {prev_x_r[COORD_W-1], prev_x_r} - {cx_r[COORD_W-1], cx_r};
            fyf_r       <= {prev_y_r[COORD_W-1], prev_y_r} - {cy_r[COORD_W-1], cy_r};
            prev_x_r    <= in_data.point_x;
            prev_y_r    <= in_data.point_y;
            have_prev_r <= 1'b1;
            state_r     <= have_prev_r ? S_PREP : S_TAIL;
          end
        end

        S_PREP: begin
          dxm_r     <= shift_k ? mdx[COORD_W:1] : mdx[COORD_W-1:0];
          dym_r     <= shift_k ? mdy[COORD_W:1] : mdy[COORD_W-1:0];
          fxm_r     <= shift_k ? mfx[COORD_W:1] : mfx[COORD_W-1:0];
          fym_r     <= shift_k ? mfy[COORD_W:1] : mfy[COORD_W-1:0];
          rm_r      <= shift_k ? {1'b0, rad_r[RADIUS_W-1:1]} : rad_r;
          dx_full_r <= mdx[COORD_W-1:0];
          dy_full_r <= mdy[COORD_W-1:0];
          dx_neg_r  <= dxf_r[COORD_W];
          dy_neg_r  <= dyf_r[COORD_W];
          fx_neg_r  <= fxf_r[COORD_W];
          fy_neg_r  <= fyf_r[COORD_W];
          mop_r     <= MOP_DXX;
          state_r   <= S_MUL;
        end

        S_MUL: begin
          state_r <= S_MWAIT;
        end

        S_MWAIT: begin
          if (mul_done) begin
            unique case (mop_r)
              MOP_DXX:  qa_r <= mul_prod[WORD_W-1:0];
              MOP_DYY:  qa_r <= qa_r + mul_prod[WORD_W-1:0];
              MOP_FXX:  qc_r <= mul_prod[WORD_W-1:0];
              MOP_FYY:  qc_r <= qc_r + mul_prod[WORD_W-1:0];
              MOP_RR:   qc_r <= qc_r - mul_prod[WORD_W-1:0];
              MOP_FXDX: h_r  <= (fx_neg_r ^ dx_neg_r) ? -mul_prod[WORD_W-1:0]
                                                      : mul_prod[WORD_W-1:0];
              MOP_FYDY: h_r  <= (fy_neg_r ^ dy_neg_r) ? h_r - mul_prod[WORD_W-1:0]
                                                      : h_r + mul_prod[WORD_W-1:0];
              MOP_HH:   disc_r <= mul_prod;
              MOP_QAQC: disc_r <= qc_r[WORD_W-1] ? disc_r + mul_prod : disc_r - mul_prod;
              default: ;
            endcase
            priority if (mop_r == MOP_FYDY && qa_r == '0) begin
              // zero-length segment: touches from inside, never a piece
              hit_r   <= (qc_r <= 0);
              quad_r  <= 1'b0;
              state_r <= S_SEG;
            end else if (mop_r == MOP_QAQC) begin
              state_r <= S_SQRT;
            end else begin
              mop_r   <= mop_t'(mop_r + 4'd1);
              state_r <= S_MUL;
            end
          end
        end

        S_SQRT: begin
          if (disc_r[WIDE_W-1]) begin
            hit_r   <= 1'b0;
            quad_r  <= 1'b0;
            state_r <= S_SEG;
          end else begin
            state_r <= S_SWAIT;
          end
        end

        S_SWAIT: begin
          if (sqrt_done) begin
            n0_r    <= -{{2{h_r[WORD_W-1]}}, h_r} - {2'b00, sqrt_root};
            n1_r    <= -{{2{h_r[WORD_W-1]}}, h_r} + {2'b00, sqrt_root};
            state_r <= S_NCHK;
          end
        end

        S_NCHK: begin
          if (n1_r < 0 || n0_r > qa_ext) begin
            hit_r   <= 1'b0;
            quad_r  <= 1'b0;
            state_r <= S_SEG;
          end else begin
            hit_r       <= 1'b1;
            quad_r      <= 1'b1;
            start_int_r <= n0_r > 0;
            end_int_r   <= n1_r < qa_ext;
            x0_r        <= ax_r;
            y0_r        <= ay_r;
            x1_r        <= px_r;
            y1_r        <= py_r;
            off_sel_r   <= 3'd0;
            state_r     <= S_OFF;
          end
        end

        S_OFF: begin
          priority if (off_sel_r[2]) begin
            state_r <= S_SEG;
          end else if (off_need) begin
            state_r <= S_OFF_MW;
          end else begin
            off_sel_r <= off_sel_r + 3'd1;
          end
        end

        S_OFF_MW: begin
          if (mul_done) begin
            state_r <= S_OFF_DW;
          end
        end

        S_OFF_DW: begin
          if (div_done) begin
            unique case (off_sel_r[1:0])
              2'd0: x0_r <= off_val;
              2'd1: y0_r <= off_val;
              2'd2: x1_r <= off_val;
              2'd3: y1_r <= off_val;
              default: ;
            endcase
            off_sel_r <= off_sel_r + 3'd1;
            state_r   <= S_OFF;
          end
        end

        S_SEG: begin
          touched_r  <= touched_r | hit_r;
          go_start_r <= crop_on && hit_r && piece_w;
          priority if (crop_on && held_valid_r && (!hit_r || (piece_w && moved_w))) begin
            state_r <= S_EMIT1;
          end else if (crop_on && hit_r && piece_w) begin
            state_r <= S_START;
          end else begin
            if (crop_on && !hit_r) begin
              held_valid_r <= 1'b0;
            end
            state_r <= S_TAIL;
          end
        end

        S_EMIT1: begin
          // close the open piece
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= '{out_x: held_x_r, out_y: held_y_r, piece_end: 1'b1,
                              overflow: 1'b0};
            held_valid_r <= 1'b0;
            state_r      <= go_start_r ? S_START : S_TAIL;
          end
        end

        S_START: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= '{out_x: x0_r, out_y: y0_r, piece_end: 1'b0, overflow: 1'b0};
            held_x_r     <= x1_r;
            held_y_r     <= y1_r;
            held_valid_r <= 1'b1;
            state_r      <= S_TAIL;
          end
        end

        S_TAIL: begin
          priority if (!last_r) begin
            state_r <= S_IDLE;
          end else if (cropped_r && held_valid_r && !supp_r) begin
            state_r <= S_ELAST;
          end else if (!cropped_r && touched_r && !supp_r) begin
            rd_idx_r <= '0;
            state_r  <= S_RD_ADDR;
          end else begin
            have_prev_r  <= 1'b0;
            held_valid_r <= 1'b0;
            touched_r    <= 1'b0;
            ovf_r        <= 1'b0;
            cnt_r        <= '0;
            state_r      <= S_IDLE;
          end
        end

        S_ELAST: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= '{out_x: held_x_r, out_y: held_y_r, piece_end: 1'b1,
                              overflow: 1'b0};
            have_prev_r  <= 1'b0;
            held_valid_r <= 1'b0;
            touched_r    <= 1'b0;
            ovf_r        <= 1'b0;
            cnt_r        <= '0;
            state_r      <= S_IDLE;
          end
        end

        S_RD_ADDR: begin
          state_r <= S_RD_OUT;
        end

        S_RD_OUT: begin
          // replay the buffered edge
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{out_x: ram_rdata[2*COORD_W-1:COORD_W],
                             out_y: ram_rdata[COORD_W-1:0],
                             piece_end: rd_end, overflow: ovf_r};
            if (rd_end) begin
              have_prev_r  <= 1'b0;
              held_valid_r <= 1'b0;
              touched_r    <= 1'b0;
              ovf_r        <= 1'b0;
              cnt_r        <= '0;
              state_r      <= S_IDLE;
            end else begin
              rd_idx_r <= rd_idx_r + AW'(1);
              state_r  <= S_RD_ADDR;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  pcc_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data ({in_data.point_x, in_data.point_y}),
    .rd_en   (ram_re),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rdata)
  );

  pcc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pcc_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .v     (disc_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  pcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   ({qa_r[WORD_W-2:0], 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

@@ sv/pcc_ram.sv @@
// generic single-port-write ram with registered read
module pcc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/pcc_mul.sv @@
// 64x64 unsigned multiplier, four 32x32 partial products over successive cycles
module pcc_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pcc_pkg::WORD_W-1:0]   a,
  input  logic [pcc_pkg::WORD_W-1:0]   b,
  output logic                         done,
  output logic [pcc_pkg::WIDE_W-1:0]   prod
);
  import pcc_pkg::*;

  logic              busy_r, done_r, pp_v_r;
  logic [2:0]        step_r;
  logic [WORD_W-1:0] a_r, b_r, pp_r, pp_w;
  logic [1:0]        sh_r;
  logic [WIDE_W-1:0] acc_r;
  logic [31:0]       a_half, b_half;

  assign a_half = step_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = step_r[0] ? b_r[63:32] : b_r[31:0];
  assign pp_w   = a_half * b_half;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pp_v_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      pp_v_r <= busy_r && !step_r[2];
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        if (step_r[2]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (pp_v_r) begin
      acc_r <= acc_r + ({64'd0, pp_r} << {sh_r, 5'd0});
    end
    if (busy_r && !step_r[2]) begin
      pp_r <= pp_w;
      sh_r <= {1'b0, step_r[1]} + {1'b0, step_r[0]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ sv/pcc_sqrt.sv @@
// iterative integer square root, one result bit per cycle
module pcc_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pcc_pkg::WIDE_W-1:0] v,
  output logic                       done,
  output logic [pcc_pkg::WORD_W-1:0] root
);
  import pcc_pkg::*;

  logic              busy_r, done_r;
  logic [5:0]        cnt_r;
  logic [WIDE_W-1:0] x_r, res_r, one_w, trial_w;
  logic              ge_w;

  assign one_w   = {{(WIDE_W-1){1'b0}}, 1'b1} << {cnt_r, 1'b0};
  assign trial_w = res_r + one_w;
  assign ge_w    = x_r >= trial_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd63;
      end else if (busy_r) begin
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= v;
      res_r <= '0;
    end else if (busy_r) begin
      if (ge_w) begin
        x_r   <= x_r - trial_w;
        res_r <= (res_r >> 1) + one_w;
      end else begin
        res_r <= res_r >> 1;
      end
    end
  end

  assign done = done_r;
  assign root = res_r[WORD_W-1:0];

endmodule

@@ sv/pcc_div.sv @@
// restoring divider, 128-bit dividend by 64-bit divisor, one bit per cycle
module pcc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pcc_pkg::WIDE_W-1:0] num,
  input  logic [pcc_pkg::WORD_W-1:0] den,
  output logic                       done,
  output logic [pcc_pkg::WORD_W-1:0] quo
);
  import pcc_pkg::*;

  logic              busy_r, done_r;
  logic [6:0]        cnt_r;
  logic [WIDE_W-1:0] n_r;
  logic [WORD_W-1:0] d_r, rem_r, q_r, rem_sh, rem_nxt;
  logic              take;

  assign rem_sh  = {rem_r[WORD_W-2:0], n_r[WIDE_W-1]};
  assign take    = rem_r[WORD_W-1] || (rem_sh >= d_r);
  assign rem_nxt = take ? rem_sh - d_r : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd127;
      end else if (busy_r) begin
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      n_r   <= n_r << 1;
      rem_r <= rem_nxt;
      q_r   <= {q_r[WORD_W-2:0], take};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ bench/pcc_clip_checker.sv @@
// clipping predictor and result scoreboard for the polyline circle clipper
module pcc_clip_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  pcc_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  pcc_pkg::out_t out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output int            mismatches,
  output int            awaited,
  output int            points_seen,
  output int            results_seen
);
  import pcc_pkg::*;

  typedef logic signed [127:0] wide_t;

  // circle settings
  logic signed [31:0] circ_x, circ_y;
  logic [30:0] circ_r;
  bit crop_on, pass_hidden, drop_smooth;

  // edge state
  longint last_x, last_y, open_x, open_y;
  bit got_last, open_valid, edge_off, edge_hit, store_full;
  logic [63:0] edge_pts[MAX_POINTS_DEF];
  int n_stored;

  out_t due_points[$];

  initial awaited = 0;

  function automatic longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint halve(longint v, bit k);
    return v < 0 ? -(mag64(v) >> k) : (v >> k);
  endfunction

  function automatic wide_t floor_root(wide_t v);
    wide_t res, c;
    res = 0;
    for (int b = 62; b >= 0; b--) begin
      c = res | (wide_t'(1) << b);
      if (c * c <= v) res = c;
    end
    return res;
  endfunction

  // rounded num * d / qa, halves away from zero
  function automatic longint step_along(wide_t num, longint d, wide_t qa);
    wide_t m, q;
    m = mag64(d);
    q = (2 * num * m + qa) / (2 * qa);
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void clip_segment(input longint ax, ay, bx, by,
                                       output bit hit, output bit piece,
                                       output longint x0, y0, x1, y1);
    longint dxf, dyf, fxf, fyf;
    bit k;
    wide_t dx, dy, fx, fy, r, qa, qc, h, disc, s, n0, n1;
    dxf = bx - ax;
    dyf = by - ay;
    fxf = ax - longint'(circ_x);
    fyf = ay - longint'(circ_y);
    k = ((mag64(dxf) | mag64(dyf) | mag64(fxf) | mag64(fyf)) >> 31) != 0;
    dx = halve(dxf, k);
    dy = halve(dyf, k);
    fx = halve(fxf, k);
    fy = halve(fyf, k);
    r = wide_t'({1'b0, circ_r} >> k);
    qa = dx * dx + dy * dy;
    qc = fx * fx + fy * fy - r * r;
    piece = 0;
    x0 = ax; y0 = ay; x1 = bx; y1 = by;
    if (qa == 0) begin
      hit = (qc <= 0);
      return;
    end
    h = fx * dx + fy * dy;
    disc = h * h - qa * qc;
    if (disc < 0) begin
      hit = 0;
      return;
    end
    s = floor_root(disc);
    n0 = -h - s;
    n1 = -h + s;
    if (n1 < 0 || n0 > qa) begin
      hit = 0;
      return;
    end
    hit = 1;
    if (n0 > 0) begin
      x0 = ax + step_along(n0, dxf, qa);
      y0 = ay + step_along(n0, dyf, qa);
    end
    if (n1 < qa) begin
      x1 = ax + step_along(n1, dxf, qa);
      y1 = ay + step_along(n1, dyf, qa);
    end
    piece = !(x0 == x1 && y0 == y1);
  endfunction

  function automatic void emit(longint x, longint y, bit pend, bit ovf);
    out_t o;
    o.out_x = x[31:0];
    o.out_y = y[31:0];
    o.piece_end = pend;
    o.overflow = ovf;
    due_points.insert(due_points.size(), o);
  endfunction

  function automatic void take_point(in_t p);
    longint px, py, x0, y0, x1, y1;
    bit hit, piece;
    px = longint'(p.point_x);
    py = longint'(p.point_y);
    if (!got_last) begin
      edge_off = (p.hidden && !pass_hidden) || (p.smooth && drop_smooth);
      edge_hit = 0;
      open_valid = 0;
      store_full = 0;
      n_stored = 0;
    end
    if (n_stored < MAX_POINTS_DEF) begin
      edge_pts[n_stored] = {p.point_x, p.point_y};
      n_stored++;
    end else begin
      store_full = 1;
    end
    if (got_last) begin
      clip_segment(last_x, last_y, px, py, hit, piece, x0, y0, x1, y1);
      if (hit) edge_hit = 1;
      if (crop_on && !edge_off) begin
        if (!hit) begin
          if (open_valid) emit(open_x, open_y, 1, 0);
          open_valid = 0;
        end else if (piece) begin
          // a piece that does not continue the open one closes it
          if (!open_valid || open_x != x0 || open_y != y0) begin
            if (open_valid) emit(open_x, open_y, 1, 0);
            open_x = x0;
            open_y = y0;
            open_valid = 1;
          end
          emit(open_x, open_y, 0, 0);
          open_x = x1;
          open_y = y1;
        end
      end
    end
    last_x = px;
    last_y = py;
    got_last = 1;
    if (p.edge_last) begin
      if (crop_on) begin
        if (open_valid && !edge_off) emit(open_x, open_y, 1, 0);
      end else if (edge_hit && !edge_off) begin
        for (int i = 0; i < n_stored; i++)
          emit(longint'($signed(edge_pts[i][63:32])), longint'($signed(edge_pts[i][31:0])),
               i + 1 == n_stored, store_full);
      end
      got_last = 0;
      open_valid = 0;
      edge_hit = 0;
      store_full = 0;
      n_stored = 0;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      circ_x <= 0; circ_y <= 0; circ_r <= 0;
      crop_on <= 1; pass_hidden <= 1; drop_smooth <= 0;
      got_last <= 0; open_valid <= 0; edge_off <= 0; edge_hit <= 0;
      store_full <= 0; n_stored <= 0;
      mismatches <= 0; points_seen <= 0; results_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CENTER_X:     circ_x = cfg_data;
          CFG_CENTER_Y:     circ_y = cfg_data;
          CFG_RADIUS:       circ_r = cfg_data[30:0];
          CFG_CROPPED:      crop_on = cfg_data[0];
          CFG_SHOW_HIDDEN:  pass_hidden = cfg_data[0];
          CFG_HIDE_TANGENT: drop_smooth = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        take_point(in_data);
        points_seen <= points_seen + 1;
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (due_points.size() == 0) begin
          $error("unexpected result beat x=%0d y=%0d", out_data.out_x, out_data.out_y);
          bad++;
        end else begin
          want = due_points.pop_front();
          if (want.out_x !== out_data.out_x) begin
            $error("out_x expected %0d actual %0d", want.out_x, out_data.out_x);
            bad++;
          end
          if (want.out_y !== out_data.out_y) begin
            $error("out_y expected %0d actual %0d", want.out_y, out_data.out_y);
            bad++;
          end
          if (want.piece_end !== out_data.piece_end) begin
            $error("piece_end expected %0b actual %0b", want.piece_end, out_data.piece_end);
            bad++;
          end
          if (want.overflow !== out_data.overflow) begin
            $error("overflow expected %0b actual %0b", want.overflow, out_data.overflow);
            bad++;
          end
        end
      end
      mismatches <= mismatches + bad;
    end
    awaited <= due_points.size();
  end

endmodule

@@ bench/polyline_circle_clipper_top_test.sv @@
// stimulus and verdict for the polyline circle clipper
module polyline_circle_clipper_top_test;
  import pcc_pkg::*;

  // far above the slowest legal run, stalls included
  localparam int CYCLE_LIMIT = 3_000_000;
  // worst segment of the block, with margin
  localparam int SETTLE = 800;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int mismatches, awaited, points_seen, results_seen;
  int cycles = 0;
  int idle_pct = 0;   // sender gap chance, percent
  int stall_pct = 0;  // receiver stall chance, percent
  int hold_left = 0;  // long receiver hold-off still to run
  int hold_req = 0;

  longint ring_x, ring_y, ring_r;  // current circle, for aiming points

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  polyline_circle_clipper_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pcc_clip_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .awaited(awaited),
    .points_seen(points_seen), .results_seen(results_seen)
  );

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != 0 && hold_left == 0) begin
      hold_left <= hold_req;
      hold_req <= 0;
      out_ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // valid stays up for a following write; the caller drops it after the last
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // wait for every awaited beat, then let a trailing segment finish
  task automatic drain();
    @(posedge clk);
    while (awaited != 0 || hold_left != 0 || hold_req != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_circle(longint cx, longint cy, longint r, bit crop, bit sh, bit ht);
    drain();
    write_reg(CFG_CENTER_X, cx[31:0]);
    write_reg(CFG_CENTER_Y, cy[31:0]);
    write_reg(CFG_RADIUS, {1'b0, r[30:0]});
    write_reg(CFG_CROPPED, {31'd0, crop});
    write_reg(CFG_SHOW_HIDDEN, {31'd0, sh});
    write_reg(CFG_HIDE_TANGENT, {31'd0, ht});
    cfg_valid <= 0;
    ring_x = longint'($signed(cx[31:0]));
    ring_y = longint'($signed(cy[31:0]));
    ring_r = r[30:0];
  endtask

  task automatic send_point(longint x, longint y, bit last, bit hid = 0, bit smo = 0);
    in_t p;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    p.point_x = x[31:0];
    p.point_y = y[31:0];
    p.edge_last = last;
    p.hidden = hid;
    p.smooth = smo;
    in_valid <= 1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 0;
  endtask

  // a coordinate near the circle, now and then anywhere at all
  function automatic longint aim(longint c);
    longint span;
    if ($urandom_range(9) == 0) return longint'($signed($urandom()));
    span = ring_r * 2 + 64;
    if (span > 64'd2147483647) span = 64'd2147483647;
    return c + longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  task automatic random_edges(int n_points);
    int left, len;
    bit hid, smo;
    left = n_points;
    while (left > 0) begin
      len = ($urandom_range(19) == 0) ? 1 : $urandom_range(2, 6);
      hid = $urandom_range(1);
      smo = $urandom_range(1);
      for (int i = 0; i < len; i++)
        send_point(aim(ring_x), aim(ring_y), i == len - 1, hid, smo);
      left -= len;
    end
    stop_sending();
  endtask

  initial begin
    longint unit;
    unit = 64'd65536;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: crossing segment, graze on a tangent, zero length, single point
    set_circle(0, 0, unit, 1, 1, 0);
    send_point(-2 * unit, 0, 0);
    send_point(2 * unit, 0, 0);
    send_point(2 * unit, unit, 0);      // outside the whole way
    send_point(-2 * unit, unit, 0);     // touches the circle at one point only
    send_point(0, 0, 0);
    send_point(0, 0, 0);                // zero-length segment inside
    send_point(unit / 2, unit / 4, 1);
    send_point(7, 7, 1);                // lone point, no segment
    // field extremes, all bits
    send_point(-64'd2147483648, 64'd2147483647, 0, 1, 1);
    send_point(64'd2147483647, -64'd2147483648, 0, 1, 1);
    send_point(-64'd2147483648, -64'd2147483648, 1, 1, 1);
    stop_sending();

    // suppression of hidden and smooth edges
    set_circle(0, 0, unit, 1, 0, 1);
    send_point(-2 * unit, 0, 0, 1, 0);
    send_point(2 * unit, 0, 1, 0, 1);
    send_point(-2 * unit, 0, 0, 0, 1);
    send_point(2 * unit, 0, 1);
    send_point(-2 * unit, 0, 0);
    send_point(2 * unit, 0, 1);
    stop_sending();

    // uncropped with an overlong edge: store truncated, overflow flagged
    set_circle(0, 0, 64'd2147483647, 0, 1, 0);
    for (int i = 0; i < 70; i++)
      send_point(i * unit, -i * unit, i == 69);
    stop_sending();

    // mode switched between the segments of one open edge
    set_circle(0, 0, unit, 1, 1, 0);
    send_point(-2 * unit, 0, 0);
    send_point(2 * unit, 0, 0);
    stop_sending();
    drain();
    write_reg(CFG_CROPPED, 32'd0);
    cfg_valid <= 0;
    send_point(0, 2 * unit, 1);
    stop_sending();

    // random phases with different circles and idling
    set_circle(0, 0, 8 * unit, 1, 1, 0);
    idle_pct = 0; stall_pct = 0;
    random_edges(35);

    set_circle(longint'($signed($urandom())), longint'($signed($urandom())),
               $urandom_range(1, 1000) * unit, 0, 0, 1);
    idle_pct = 70; stall_pct = 0;
    random_edges(35);

    set_circle(-3 * unit, 5 * unit, 2 * unit, 1, 0, 0);
    idle_pct = 0; stall_pct = 70;
    random_edges(35);

    // long hold-off while the sender keeps offering beats
    set_circle(unit, unit, 4 * unit, 0, 1, 1);
    idle_pct = 0; stall_pct = 0;
    hold_req = 4000;
    random_edges(30);

    set_circle(0, 0, 0, 1, 1, 0);        // zero radius
    idle_pct = 27; stall_pct = 27;
    random_edges(20);

    set_circle(-64'd2147483648, 64'd2147483647, 64'd2147483647, 1, 1, 1);
    random_edges(30);

    set_circle($urandom_range(0, 100) * unit, 0, 50 * unit, 0, 1, 0);
    idle_pct = 0; stall_pct = 0;
    random_edges(25);

    drain();
    $display("%0d points sent across circles of zero to full radius, both modes", points_seen);
    $display("%0d result beats compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && awaited == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
